>>> sv/dqs_pkg.sv
// Shared types, constants and tables for the debounced quadrature setpoint unit.
package dqs_pkg;

    localparam int CountWidth    = 10;
    localparam int SetpointWidth = 16;
    localparam int DigitWidth    = 2;
    localparam int PhaseWidth    = 2;
    localparam int StepWidth     = 2;
    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 16;
    localparam int MultWidth     = 10;

    typedef logic [CountWidth-1:0]           count_t;
    typedef logic signed [SetpointWidth-1:0] setpoint_t;
    typedef logic [DigitWidth-1:0]           digit_t;
    typedef logic [PhaseWidth-1:0]           phase_t;
    typedef logic signed [StepWidth-1:0]     step_t;
    typedef logic [MultWidth-1:0]            mult_t;

    // configuration register indexes
    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_DEBOUNCE_LIMIT   = 2'd0,
        CFG_SETPOINT_FLOOR   = 2'd1,
        CFG_SETPOINT_CEILING = 2'd2
    } cfg_index_t;

    localparam count_t    DEBOUNCE_LIMIT_RESET   = count_t'(100);
    localparam setpoint_t SETPOINT_FLOOR_RESET   = setpoint_t'(-3000);
    localparam setpoint_t SETPOINT_CEILING_RESET = setpoint_t'(3000);

    localparam step_t STEP_NONE = 2'sb00;
    localparam step_t STEP_UP   = 2'sb01;
    localparam step_t STEP_DOWN = 2'sb11;

    // indexed by {prior phase, current phase}
    localparam step_t STEP_TABLE [16] = '{
        STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE,
        STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
        STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
        STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE
    };

    localparam mult_t POW10_TABLE [4] = '{
        mult_t'(1), mult_t'(10), mult_t'(100), mult_t'(1000)
    };

endpackage

>>> sv/dqs_debounce.sv
// Integrator debouncer for one encoder pin.
module dqs_debounce
    import dqs_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   update,
    input  logic   raw_level,
    input  count_t limit,
    output logic   clean_next
);

    count_t count_reg, count_next;
    logic   clean_reg;
    count_t count_step;

    always_comb begin
        if (!raw_level) begin
            count_step = (count_reg != '0) ? count_reg - count_t'(1) : count_reg;
        end else begin
            count_step = (count_reg < limit) ? count_reg + count_t'(1) : count_reg;
        end
        count_next = count_step;
        clean_next = clean_reg;
        // zero is tested first, so a zero limit holds the pin low
        if (count_step == '0) begin
            clean_next = 1'b0;
        end else if (count_step >= limit) begin
            count_next = limit;
            clean_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            clean_reg <= 1'b1;
        end else if (update) begin
            count_reg <= count_next;
            clean_reg <= clean_next;
        end
    end

endmodule

>>> sv/dqs_adjust.sv
// Phase transition decode and saturating setpoint step.
module dqs_adjust
    import dqs_pkg::*;
(
    input  phase_t    prior_phase,
    input  phase_t    phase,
    input  digit_t    digit,
    input  setpoint_t setpoint,
    input  setpoint_t floor_val,
    input  setpoint_t ceiling_val,
    output step_t     step,
    output setpoint_t result
);

    logic signed [SetpointWidth:0] sp_ext;
    logic signed [SetpointWidth:0] mult_ext;
    logic signed [SetpointWidth:0] dec_val;
    logic signed [SetpointWidth:0] inc_val;
    logic signed [SetpointWidth:0] floor_ext;
    logic signed [SetpointWidth:0] ceiling_ext;

    always_comb begin
        step        = STEP_TABLE[{prior_phase, phase}];
        sp_ext      = {setpoint[SetpointWidth-1], setpoint};
        mult_ext    = signed'({{(SetpointWidth+1-MultWidth){1'b0}}, POW10_TABLE[digit]});
        floor_ext   = {floor_val[SetpointWidth-1], floor_val};
        ceiling_ext = {ceiling_val[SetpointWidth-1], ceiling_val};
        dec_val     = sp_ext - mult_ext;
        inc_val     = sp_ext + mult_ext;
        // each direction checks only its own bound
        if (step == STEP_DOWN) begin
            result = (dec_val >= floor_ext) ? dec_val[SetpointWidth-1:0] : floor_val;
        end else if (step == STEP_UP) begin
            result = (inc_val <= ceiling_ext) ? inc_val[SetpointWidth-1:0] : ceiling_val;
        end else begin
            result = setpoint;
        end
    end

endmodule

>>> sv/debounced_quadrature_setpoint_unit.sv
// Top level: input register, debounce and decode, result register.
// A word accepted into the input register is debounced and decoded, then registered on the m_ port when it advances.
// Throughput: one word per cycle while m_ready is high; the per-tick state update closes the loop that sets this rate.
// Reset (aresetn low, synchronous): both stages empty, integrators zero, clean levels high,
// prior phase zero, registers at limit 100, floor -3000, ceiling 3000.
module debounced_quadrature_setpoint_unit
    import dqs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_pin_a_level,
    input  logic                     s_pin_b_level,
    input  digit_t                   s_digit_position,
    input  setpoint_t                s_setpoint_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output step_t                    m_step_direction,
    output setpoint_t                m_setpoint_out,
    output phase_t                   m_phase_now
);

    count_t    limit_reg;
    setpoint_t floor_reg;
    setpoint_t ceiling_reg;

    logic      in_valid_reg;
    logic      pin_a_reg;
    logic      pin_b_reg;
    digit_t    digit_reg;
    setpoint_t setpoint_reg;

    phase_t    prior_phase_reg;
    logic      out_valid_reg;
    step_t     step_reg;
    setpoint_t result_reg;
    phase_t    phase_reg;

    logic      advance;
    logic      clean_a;
    logic      clean_b;
    phase_t    phase;
    step_t     step;
    setpoint_t result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= DEBOUNCE_LIMIT_RESET;
            floor_reg   <= SETPOINT_FLOOR_RESET;
            ceiling_reg <= SETPOINT_CEILING_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEBOUNCE_LIMIT:   limit_reg   <= cfg_wdata[CountWidth-1:0];
                CFG_SETPOINT_FLOOR:   floor_reg   <= setpoint_t'(cfg_wdata);
                CFG_SETPOINT_CEILING: ceiling_reg <= setpoint_t'(cfg_wdata);
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pin_a_reg    <= s_pin_a_level;
            pin_b_reg    <= s_pin_b_level;
            digit_reg    <= s_digit_position;
            setpoint_reg <= s_setpoint_in;
        end
    end

    dqs_debounce u_debounce_a (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .update     (advance),
        .raw_level  (pin_a_reg),
        .limit      (limit_reg),
        .clean_next (clean_a)
    );

    dqs_debounce u_debounce_b (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .update     (advance),
        .raw_level  (pin_b_reg),
        .limit      (limit_reg),
        .clean_next (clean_b)
    );

    // pins are active low
    assign phase = {~clean_b, ~clean_a};

    dqs_adjust u_adjust (
        .prior_phase (prior_phase_reg),
        .phase       (phase),
        .digit       (digit_reg),
        .setpoint    (setpoint_reg),
        .floor_val   (floor_reg),
        .ceiling_val (ceiling_reg),
        .step        (step),
        .result      (result)
    );

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prior_phase_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (advance) begin
                prior_phase_reg <= phase;
                out_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            step_reg   <= step;
            result_reg <= result;
            phase_reg  <= phase;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_step_direction = step_reg;
    assign m_setpoint_out   = result_reg;
    assign m_phase_now      = phase_reg;

endmodule

>>> sim/tb_debounced_quadrature_setpoint_unit.sv
// Self-checking testbench for the debounced quadrature setpoint unit.
module tb_debounced_quadrature_setpoint_unit;
    import dqs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 11;

    logic                     aclk             = 1'b0;
    logic                     aresetn          = 1'b0;
    logic                     cfg_wr_en        = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index        = '0;
    logic [CfgDataWidth-1:0]  cfg_wdata        = '0;
    logic                     s_valid          = 1'b0;
    logic                     s_ready;
    logic                     s_pin_a_level    = 1'b1;
    logic                     s_pin_b_level    = 1'b1;
    digit_t                   s_digit_position = '0;
    setpoint_t                s_setpoint_in    = '0;
    logic                     m_valid;
    logic                     m_ready          = 1'b0;
    step_t                    m_step_direction;
    setpoint_t                m_setpoint_out;
    phase_t                   m_phase_now;

    bit steady = 1'b0;
    int cycles = 0;

    typedef struct packed {
        step_t     step;
        setpoint_t setpoint;
        phase_t    phase;
    } knob_word_t;

    class setpoint_scoreboard;
        count_t     limit;
        setpoint_t  sp_floor;
        setpoint_t  sp_ceiling;
        count_t     cnt_a;
        count_t     cnt_b;
        logic       lvl_a;
        logic       lvl_b;
        phase_t     last_phase;
        knob_word_t expected_words[$];
        int         errors;

        function new();
            limit      = DEBOUNCE_LIMIT_RESET;
            sp_floor   = SETPOINT_FLOOR_RESET;
            sp_ceiling = SETPOINT_CEILING_RESET;
            cnt_a      = '0;
            cnt_b      = '0;
            lvl_a      = 1'b1;
            lvl_b      = 1'b1;
            last_phase = '0;
            errors     = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [CfgDataWidth-1:0] data);
            case (idx)
                CFG_DEBOUNCE_LIMIT:   limit      = count_t'(data);
                CFG_SETPOINT_FLOOR:   sp_floor   = setpoint_t'(data);
                CFG_SETPOINT_CEILING: sp_ceiling = setpoint_t'(data);
                default: ;
            endcase
        endfunction

        // zero is tested before the limit, so a zero limit pins the level low
        function void integrate(input logic raw, inout count_t cnt, inout logic lvl);
            int c;
            c = int'(cnt);
            if (!raw) begin
                if (c > 0) c--;
            end else if (c < int'(limit)) begin
                c++;
            end
            if (c == 0) begin
                lvl = 1'b0;
            end else if (c >= int'(limit)) begin
                c   = int'(limit);
                lvl = 1'b1;
            end
            cnt = count_t'(c);
        endfunction

        function void note_word(logic a, logic b, digit_t d, setpoint_t sp);
            knob_word_t w;
            logic [1:0] was;
            logic [1:0] now;
            logic [1:0] turn;
            int         mult;
            int         t;
            integrate(a, cnt_a, lvl_a);
            integrate(b, cnt_b, lvl_b);
            w.phase = {~lvl_b, ~lvl_a};
            // position along the forward cycle 0, 2, 3, 1
            was  = {last_phase[0], last_phase[0] ^ last_phase[1]};
            now  = {w.phase[0], w.phase[0] ^ w.phase[1]};
            turn = now - was;
            last_phase = w.phase;
            mult = 1;
            for (int i = 0; i < int'(d); i++) mult = mult * 10;
            t = int'(sp);
            w.step     = STEP_NONE;
            w.setpoint = sp;
            // each direction clamps against its own bound only
            case (turn)
                2'd1: begin
                    w.step     = STEP_UP;
                    t          = t + mult;
                    w.setpoint = (t > int'(sp_ceiling)) ? sp_ceiling : setpoint_t'(t);
                end
                2'd3: begin
                    w.step     = STEP_DOWN;
                    t          = t - mult;
                    w.setpoint = (t < int'(sp_floor)) ? sp_floor : setpoint_t'(t);
                end
                default: ;
            endcase
            expected_words.push_back(w);
        endfunction

        function void check_word(step_t st, setpoint_t sp, phase_t ph);
            knob_word_t w;
            if (expected_words.size() == 0) begin
                $error("unexpected result word: step_direction %0d setpoint_out %0d phase_now %0d",
                       st, sp, ph);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            if (st !== w.step) begin
                $error("step_direction: expected %0d, actual %0d", w.step, st);
                errors++;
            end
            if (sp !== w.setpoint) begin
                $error("setpoint_out: expected %0d, actual %0d", w.setpoint, sp);
                errors++;
            end
            if (ph !== w.phase) begin
                $error("phase_now: expected %0d, actual %0d", w.phase, ph);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    setpoint_scoreboard sb = new();

    debounced_quadrature_setpoint_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pin_a_level    (s_pin_a_level),
        .s_pin_b_level    (s_pin_b_level),
        .s_digit_position (s_digit_position),
        .s_setpoint_in    (s_setpoint_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_step_direction (m_step_direction),
        .m_setpoint_out   (m_setpoint_out),
        .m_phase_now      (m_phase_now)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 27);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word(m_step_direction, m_setpoint_out, m_phase_now);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic a, input logic b, input digit_t d,
                             input setpoint_t sp);
        while (!steady && $urandom_range(0, 99) < 27) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_pin_a_level    <= a;
        s_pin_b_level    <= b;
        s_digit_position <= d;
        s_setpoint_in    <= sp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_word(a, b, d, sp);
        @(negedge aclk);
    endtask

    task automatic stop_and_drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic write_settings(input int lim, input int lo, input int hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DEBOUNCE_LIMIT;
        cfg_wdata <= CfgDataWidth'(lim);
        sb.set_register(CFG_DEBOUNCE_LIMIT, CfgDataWidth'(lim));
        @(negedge aclk);
        cfg_index <= CFG_SETPOINT_FLOOR;
        cfg_wdata <= CfgDataWidth'(lo);
        sb.set_register(CFG_SETPOINT_FLOOR, CfgDataWidth'(lo));
        @(negedge aclk);
        cfg_index <= CFG_SETPOINT_CEILING;
        cfg_wdata <= CfgDataWidth'(hi);
        sb.set_register(CFG_SETPOINT_CEILING, CfgDataWidth'(hi));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly near the bounds so saturation is hit often
    function automatic setpoint_t pick_setpoint();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel >= 8)
            return setpoint_t'($urandom_range(0, 65535));
        v = (sel < 4) ? int'(sb.sp_floor) : int'(sb.sp_ceiling);
        v = v + int'($urandom_range(0, 2200)) - 1100;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return setpoint_t'(v);
    endfunction

    // knob turning: detents held long enough to debounce, with bounce,
    // reversals, skipped states and bursts of noise mixed in
    task automatic run_phase(input int n_words);
        int         sent;
        int         hold;
        int         dir;
        int         sel;
        int         g;
        logic [1:0] pos;
        logic       a;
        logic       b;
        sent = 0;
        dir  = 1;
        pos  = 2'($urandom_range(0, 3));
        while (sent < n_words) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                hold = $urandom_range(1, 8);
                for (int i = 0; i < hold && sent < n_words; i++) begin
                    send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              digit_t'($urandom_range(0, 3)), pick_setpoint());
                    sent++;
                end
            end else begin
                if (sel < 18) begin
                    pos = pos + 2'd2;
                end else begin
                    if (sel < 30) dir = -dir;
                    pos = pos + 2'(dir);
                end
                if (sb.limit <= 24)
                    hold = int'(sb.limit) + int'($urandom_range(1, 3));
                else
                    hold = $urandom_range(1, 40);
                for (int i = 0; i < hold && sent < n_words; i++) begin
                    a = pos[1] ^ pos[0];
                    b = pos[1];
                    g = $urandom_range(0, 99);
                    if (g < 4)
                        a = ~a;
                    else if (g < 8)
                        b = ~b;
                    send_word(a, b, digit_t'($urandom_range(0, 3)), pick_setpoint());
                    sent++;
                end
            end
        end
    endtask

    int lim_tab [PHASES] = '{1, 3, 1023, 2, 0, 4, 1, 20, 5, 2, 1};
    int lo_tab  [PHASES] = '{-3000, -32768, -100, 32767, -3000, 0, -5, -2000, -20000,
                             -32768, 32000};
    int hi_tab  [PHASES] = '{3000, 32767, 100, -32768, 3000, 0, 5, 2500, 20000,
                             -32000, 32767};
    int len_tab [PHASES] = '{180, 200, 60, 150, 40, 150, 150, 200, 150, 120, 100};

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: first sample drives the clean levels low
        send_word(1'b0, 1'b0, 2'd0, setpoint_t'(0));
        send_word(1'b1, 1'b1, 2'd3, setpoint_t'(32767));
        stop_and_drain();

        // limit 1: clean level follows the pin; walk both ways across the bounds
        write_settings(1, -3000, 3000);
        send_word(1'b1, 1'b1, 2'd0, setpoint_t'(-32768));
        send_word(1'b0, 1'b1, 2'd0, setpoint_t'(-32768));
        send_word(1'b0, 1'b0, 2'd1, setpoint_t'(-2995));
        send_word(1'b1, 1'b0, 2'd2, setpoint_t'(-2000));
        send_word(1'b1, 1'b1, 2'd3, setpoint_t'(32767));
        send_word(1'b1, 1'b0, 2'd3, setpoint_t'(2500));
        send_word(1'b0, 1'b0, 2'd2, setpoint_t'(32767));
        send_word(1'b0, 1'b1, 2'd1, setpoint_t'(-32768));
        send_word(1'b1, 1'b1, 2'd0, setpoint_t'(2999));
        send_word(1'b1, 1'b1, 2'd0, setpoint_t'(5));
        send_word(1'b0, 1'b0, 2'd3, setpoint_t'(100));
        send_word(1'b1, 1'b1, 2'd2, setpoint_t'(-1));
        stop_and_drain();

        // floor above ceiling
        write_settings(1, 1000, -1000);
        send_word(1'b1, 1'b0, 2'd0, setpoint_t'(0));
        send_word(1'b1, 1'b1, 2'd0, setpoint_t'(0));
        stop_and_drain();

        // build counts above a limit, then lower the limit under them
        write_settings(4, -32768, 32767);
        send_word(1'b0, 1'b0, 2'd3, setpoint_t'(32767));
        send_word(1'b1, 1'b1, 2'd3, setpoint_t'(-32768));
        send_word(1'b1, 1'b1, 2'd1, setpoint_t'(0));
        stop_and_drain();
        write_settings(1, -32768, 32767);
        send_word(1'b0, 1'b1, 2'd2, setpoint_t'(32767));
        stop_and_drain();

        // zero limit
        write_settings(0, -32768, 32767);
        send_word(1'b1, 1'b1, 2'd3, setpoint_t'(-32768));
        send_word(1'b1, 1'b0, 2'd0, setpoint_t'(32767));
        send_word(1'b0, 1'b1, 2'd1, setpoint_t'(1234));
        stop_and_drain();

        for (int p = 0; p < PHASES; p++) begin
            write_settings(lim_tab[p], lo_tab[p], hi_tab[p]);
            steady = (p == 1);
            if (p == 0) begin
                // sender holds off until every result word is back
                run_phase(len_tab[p] / 2);
                stop_and_drain();
                run_phase(len_tab[p] - len_tab[p] / 2);
            end else begin
                run_phase(len_tab[p]);
            end
            stop_and_drain();
        end
        steady = 1'b0;

        repeat (4) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
